// ===== rtl/tea_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the round function for the TEA block cipher.
// No dependencies.
package tea_pkg;

    localparam int ROUND_COUNT_BITS = 8;
    localparam int WORD_BITS        = 32;
    localparam int ADDR_BITS        = 5;

    localparam logic [WORD_BITS-1:0] TEA_DELTA = 32'h9e3779b9;
    localparam logic [ROUND_COUNT_BITS-1:0] ROUND_COUNT_RESET = ROUND_COUNT_BITS'(32);

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_KEY_WORD0    = 3'd0;
    localparam logic [2:0] REG_KEY_WORD1    = 3'd1;
    localparam logic [2:0] REG_KEY_WORD2    = 3'd2;
    localparam logic [2:0] REG_KEY_WORD3    = 3'd3;
    localparam logic [2:0] REG_ROUND_COUNT  = 3'd4;
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd5;

    typedef struct packed {
        logic [WORD_BITS-1:0]        key_word0;
        logic [WORD_BITS-1:0]        key_word1;
        logic [WORD_BITS-1:0]        key_word2;
        logic [WORD_BITS-1:0]        key_word3;
        logic [ROUND_COUNT_BITS-1:0] round_count;
        logic                        decrypt_mode;
    } tea_cfg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic round;
        logic emit;
    } tea_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } tea_stat_t;

    function automatic logic [WORD_BITS-1:0] tea_mix(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] sum,
        input logic [WORD_BITS-1:0] ka,
        input logic [WORD_BITS-1:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ===== rtl/tea_cfg.sv =====
`timescale 1ns / 1ps
// APB-style register file: key words, round count and mode.
// Depends on tea_pkg.
module tea_cfg
    import tea_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [WORD_BITS-1:0] pwdata,
    output logic [WORD_BITS-1:0] prdata,
    output logic                 pready,
    output tea_cfg_t             cfg
);

    tea_cfg_t   cfg_reg;
    tea_cfg_t   cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                REG_KEY_WORD0:    cfg_next.key_word0    = pwdata;
                REG_KEY_WORD1:    cfg_next.key_word1    = pwdata;
                REG_KEY_WORD2:    cfg_next.key_word2    = pwdata;
                REG_KEY_WORD3:    cfg_next.key_word3    = pwdata;
                REG_ROUND_COUNT:  cfg_next.round_count  = pwdata[ROUND_COUNT_BITS-1:0];
                REG_DECRYPT_MODE: cfg_next.decrypt_mode = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_word0    <= '0;
            cfg_reg.key_word1    <= '0;
            cfg_reg.key_word2    <= '0;
            cfg_reg.key_word3    <= '0;
            cfg_reg.round_count  <= ROUND_COUNT_RESET;
            cfg_reg.decrypt_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            REG_KEY_WORD0:    prdata = cfg_reg.key_word0;
            REG_KEY_WORD1:    prdata = cfg_reg.key_word1;
            REG_KEY_WORD2:    prdata = cfg_reg.key_word2;
            REG_KEY_WORD3:    prdata = cfg_reg.key_word3;
            REG_ROUND_COUNT:  prdata = WORD_BITS'(cfg_reg.round_count);
            REG_DECRYPT_MODE: prdata = WORD_BITS'(cfg_reg.decrypt_mode);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tea_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the TEA datapath: load, prepare the sum, run rounds, emit.
// Depends on tea_pkg.
module tea_ctrl
    import tea_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tea_stat_t stat,
    output tea_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        cmd.load  = s_valid & s_ready_reg;
        cmd.prep  = (state_reg == ST_PREP);
        cmd.round = (state_reg == ST_RUN) & ~stat.cnt_zero;
        cmd.emit  = (state_reg == ST_RUN) & stat.cnt_zero & stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid & s_ready_reg) begin
                        state_reg   <= ST_PREP;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    // hold with the finished block until the output stage frees up
                    if (stat.cnt_zero & stat.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/tea_dp.sv =====
`timescale 1ns / 1ps
// TEA datapath: block words, running sum, round counter and output stage.
// Depends on tea_pkg.
module tea_dp
    import tea_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tea_cfg_t             cfg,
    input  tea_cmd_t             cmd,
    output tea_stat_t            stat,
    input  logic [WORD_BITS-1:0] s_block_low,
    input  logic [WORD_BITS-1:0] s_block_high,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_result_low,
    output logic [WORD_BITS-1:0] m_result_high
);

    logic [WORD_BITS-1:0]        v0_reg, v0_next;
    logic [WORD_BITS-1:0]        v1_reg, v1_next;
    logic [WORD_BITS-1:0]        sum_reg;
    logic [ROUND_COUNT_BITS-1:0] cnt_reg;
    logic                        decrypt_reg;
    logic [WORD_BITS-1:0]        start_sum;
    logic [WORD_BITS-1:0]        out_low_reg;
    logic [WORD_BITS-1:0]        out_high_reg;
    logic                        out_valid_reg;

    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.out_free = ~out_valid_reg | m_ready;

    assign m_valid       = out_valid_reg;
    assign m_result_low  = out_low_reg;
    assign m_result_high = out_high_reg;

    // Decrypt starts from rounds * delta; encrypt keeps the sum one step ahead
    always_comb begin
        if (decrypt_reg) begin
            start_sum = WORD_BITS'(cnt_reg) * TEA_DELTA;
        end else begin
            start_sum = TEA_DELTA;
        end
    end

    // One full TEA cycle
    always_comb begin
        if (decrypt_reg) begin
            v1_next = v1_reg - tea_mix(v0_reg, sum_reg, cfg.key_word2, cfg.key_word3);
            v0_next = v0_reg - tea_mix(v1_next, sum_reg, cfg.key_word0, cfg.key_word1);
        end else begin
            v0_next = v0_reg + tea_mix(v1_reg, sum_reg, cfg.key_word0, cfg.key_word1);
            v1_next = v1_reg + tea_mix(v0_next, sum_reg, cfg.key_word2, cfg.key_word3);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v0_reg      <= s_block_low;
            v1_reg      <= s_block_high;
            cnt_reg     <= cfg.round_count;
            decrypt_reg <= cfg.decrypt_mode;
        end else if (cmd.round) begin
            v0_reg  <= v0_next;
            v1_reg  <= v1_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.prep) begin
            sum_reg <= start_sum;
        end else if (cmd.round) begin
            sum_reg <= decrypt_reg ? (sum_reg - TEA_DELTA) : (sum_reg + TEA_DELTA);
        end
        if (cmd.emit) begin
            out_low_reg  <= v0_reg;
            out_high_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            // drop the beat once taken
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/tea_block_cipher.sv =====
`timescale 1ns / 1ps
// TEA block cipher top level: register file, sequencer and datapath.
// Depends on tea_pkg, tea_cfg, tea_ctrl, tea_dp.
//
//  Channel   Ports                                   Direction  Beat
//  input     s_valid/s_ready, s_block_low/high       in         one 64-bit block
//  result    m_valid/m_ready, m_result_low/high      out        one 64-bit block
//  config    psel/penable/pwrite/paddr/pwdata/...    in         one 32-bit register
//
// From acceptance to a valid result: a block loads at the accepting edge, the prepare state forms
// the starting sum (one 8x32 multiply in decrypt), one full TEA cycle runs per clock in the
// round unit, then the result moves into the output register.
// One block is in the round unit at a time; a new block is taken only once the last result has
// moved into the output register, so the next is taken while the result waits.
// Reset is synchronous on aresetn low; it clears control state and loads the
// register defaults. A stalled result holds the round unit until m_ready.
module tea_block_cipher
    import tea_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [WORD_BITS-1:0] pwdata,
    output logic [WORD_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_block_low,
    input  logic [WORD_BITS-1:0] s_block_high,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_result_low,
    output logic [WORD_BITS-1:0] m_result_high
);

    tea_cfg_t  cfg;
    tea_cmd_t  cmd;
    tea_stat_t stat;

    tea_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tea_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tea_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_block_low   (s_block_low),
        .s_block_high  (s_block_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_low  (m_result_low),
        .m_result_high (m_result_high)
    );

endmodule
